[design/fhm_pkg.sv]
package fhm_pkg;

  // number of task ids and depth of the waiter ring
  localparam int MAX_TASKS = 16;
  localparam int ID_W      = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  // request kinds
  localparam logic [1:0] OP_TRY    = 2'd0;
  localparam logic [1:0] OP_LOCK   = 2'd1;
  localparam logic [1:0] OP_UNLOCK = 2'd2;
  localparam logic [1:0] OP_SPARE  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BUSY      = 3'd1;
  localparam logic [2:0] ST_QUEUED    = 3'd2;
  localparam logic [2:0] ST_BADCTX    = 3'd3;
  localparam logic [2:0] ST_RECURSIVE = 3'd4;
  localparam logic [2:0] ST_NOTOWNER  = 3'd5;
  localparam logic [2:0] ST_FULL      = 3'd6;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] caller_task;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic       woken_valid;
    logic [3:0] woken_task;
    logic       mutex_locked;
    logic [3:0] mutex_owner;
  } rsp_t;

  // ring pointer advance with wrap at the ring depth
  function automatic logic [ID_W-1:0] ring_next(input logic [ID_W-1:0] pos);
    logic [ID_W-1:0] res;
    if (pos == ID_W'(MAX_TASKS - 1)) begin
      res = '0;
    end else begin
      res = pos + ID_W'(1);
    end
    return res;
  endfunction

endpackage

[design/fifo_handoff_mutex.sv]
// a request beat is accepted while the ring head is read, and the result beat is
// registered when the update stage executes; out_valid follows that register
// a new request is accepted only in the idle state, after the last one has left the
// update stage; a waiting result holds the next request in the update stage
// reset (rst_n low, synchronous): mutex free, owner 0, ring empty, no result pending;
// ring contents are not cleared and are only read behind the waiter count
module fifo_handoff_mutex (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  fhm_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output fhm_pkg::rsp_t out_data
);
  import fhm_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic             state_r, state_nxt;
  req_t             req_r;
  logic             held_r, held_nxt;
  logic [ID_W-1:0]  owner_r, owner_nxt;
  logic [ID_W-1:0]  head_r, head_nxt;
  logic [ID_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  rsp_t             out_r, rsp;

  logic             in_fire;
  logic             exec_go;
  logic             push;
  logic [ID_W-1:0]  head_data;
  logic [ID_W-1:0]  me;
  logic             ctx_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign exec_go   = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // waiter ring, read at the head while the request waits for its update cycle
  fhm_ram #(
    .WIDTH(ID_W),
    .DEPTH(MAX_TASKS)
  ) u_ring (
    .clk  (clk),
    .we   (push),
    .waddr(tail_r),
    .wdata(me),
    .raddr(head_r),
    .rdata(head_data)
  );

  assign me     = req_r.caller_task[ID_W-1:0];
  assign ctx_ok = (req_r.caller_task < 8'(MAX_TASKS)) && (req_r.op != OP_SPARE);

  // mutex decision and state update
  always_comb begin
    held_nxt  = held_r;
    owner_nxt = owner_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    push      = 1'b0;
    rsp       = '0;
    rsp.status = ST_BADCTX;
    if (ctx_ok) begin
      if (req_r.op == OP_UNLOCK) begin
        if (!held_r || owner_r != me) begin
          rsp.status = ST_NOTOWNER;
        end else if (cnt_r != '0) begin
          owner_nxt       = head_data;
          head_nxt        = ring_next(head_r);
          cnt_nxt         = cnt_r - CNT_W'(1);
          rsp.woken_valid = 1'b1;
          rsp.woken_task  = 4'(head_data);
          rsp.status      = ST_OK;
        end else begin
          held_nxt   = 1'b0;
          owner_nxt  = '0;
          rsp.status = ST_OK;
        end
      end else if (!held_r) begin
        held_nxt   = 1'b1;
        owner_nxt  = me;
        rsp.status = ST_OK;
      end else if (owner_r == me) begin
        rsp.status = ST_RECURSIVE;
      end else if (req_r.op == OP_TRY) begin
        rsp.status = ST_BUSY;
      end else if (cnt_r == CNT_W'(MAX_TASKS)) begin
        rsp.status = ST_FULL;
      end else begin
        push       = exec_go;
        tail_nxt   = ring_next(tail_r);
        cnt_nxt    = cnt_r + CNT_W'(1);
        rsp.status = ST_QUEUED;
      end
    end
    rsp.mutex_locked = held_nxt;
    rsp.mutex_owner  = held_nxt ? 4'(owner_nxt) : 4'd0;
  end

  // sequencer and result register control
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      held_r      <= 1'b0;
      owner_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_go) begin
        held_r  <= held_nxt;
        owner_r <= owner_nxt;
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_data;
    end
    if (exec_go) begin
      out_r <= rsp;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_TASKS))
    else $error("waiter count beyond ring depth");

  a_free_no_waiters: assert property (@(posedge clk) disable iff (!rst_n)
    !held_r |-> cnt_r == '0)
    else $error("waiters present while mutex is free");

  a_woken_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.woken_valid |-> out_r.status == ST_OK && out_r.mutex_locked)
    else $error("hand-off reported without lock held");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_EXEC)
    else $error("accepted request did not enter update stage");
`endif

endmodule

[design/fhm_ram.sv]
module fhm_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[test/tb_fifo_handoff_mutex.sv]
module tb_fifo_handoff_mutex;
  import fhm_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  // shadow copy of the mutex and its waiter ring
  logic             mx_held;
  logic [ID_W-1:0]  mx_owner;
  logic [ID_W-1:0]  wait_ring [MAX_TASKS];
  logic [ID_W-1:0]  wait_head;
  logic [ID_W-1:0]  wait_tail;
  logic [CNT_W-1:0] wait_cnt;

  rsp_t rsp_due [$];
  rsp_t want;
  int   fail_cnt = 0;
  int   src_idle_pct = 0;
  int   sink_idle_pct = 0;
  int   hold_ask = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  fifo_handoff_mutex i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ring pointer advance
  function automatic logic [ID_W-1:0] wrap_inc(input logic [ID_W-1:0] pos);
    return (int'(pos) == MAX_TASKS - 1) ? '0 : pos + 1'b1;
  endfunction

  // apply one request to the shadow mutex, return the result beat it should give
  function automatic rsp_t apply_mutex_req(input req_t r);
    rsp_t res;
    logic [ID_W-1:0] me;
    res = '0;
    res.status = ST_BADCTX;
    me = r.caller_task[ID_W-1:0];
    if (r.caller_task < MAX_TASKS && r.op != OP_SPARE) begin
      if (r.op == OP_UNLOCK) begin
        if (!mx_held || mx_owner != me) begin
          res.status = ST_NOTOWNER;
        end else if (wait_cnt != 0) begin
          mx_owner = wait_ring[wait_head];
          wait_head = wrap_inc(wait_head);
          wait_cnt = wait_cnt - 1'b1;
          res.woken_valid = 1'b1;
          res.woken_task = mx_owner;
          res.status = ST_OK;
        end else begin
          mx_held = 1'b0;
          mx_owner = '0;
          res.status = ST_OK;
        end
      end else if (!mx_held) begin
        mx_held = 1'b1;
        mx_owner = me;
        res.status = ST_OK;
      end else if (mx_owner == me) begin
        res.status = ST_RECURSIVE;
      end else if (r.op == OP_TRY) begin
        res.status = ST_BUSY;
      end else if (wait_cnt >= MAX_TASKS) begin
        res.status = ST_FULL;
      end else begin
        wait_ring[wait_tail] = me;
        wait_tail = wrap_inc(wait_tail);
        wait_cnt = wait_cnt + 1'b1;
        res.status = ST_QUEUED;
      end
    end
    res.mutex_locked = mx_held;
    res.mutex_owner = mx_held ? mx_owner : '0;
    return res;
  endfunction

  // offer one request beat, hold it until accepted, then predict its result
  task automatic send_req(input logic [1:0] op, input logic [7:0] caller);
    req_t r;
    r.op = op;
    r.caller_task = caller;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rsp_due.push_back(apply_mutex_req(r));
  endtask

  // sender stops until every result beat is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("mismatch on %s: got %0d, expected %0d", what, got, exp_val);
    fail_cnt++;
  endtask

  // receiver: random stalls, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (rsp_due.size() == 0) begin
        report_mismatch("unexpected result beat, status", out_data.status, 0);
      end else begin
        want = rsp_due.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.woken_valid !== want.woken_valid)
          report_mismatch("woken_valid", out_data.woken_valid, want.woken_valid);
        if (out_data.woken_task !== want.woken_task)
          report_mismatch("woken_task", out_data.woken_task, want.woken_task);
        if (out_data.mutex_locked !== want.mutex_locked)
          report_mismatch("mutex_locked", out_data.mutex_locked, want.mutex_locked);
        if (out_data.mutex_owner !== want.mutex_owner)
          report_mismatch("mutex_owner", out_data.mutex_owner, want.mutex_owner);
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // grant, busy, recursive and unlock errors on a single task pair
  task automatic test_basic_grant();
    send_req(OP_TRY, 8'd3);
    send_req(OP_TRY, 8'd5);
    send_req(OP_LOCK, 8'd3);
    send_req(OP_UNLOCK, 8'd5);
    send_req(OP_UNLOCK, 8'd3);
    send_req(OP_UNLOCK, 8'd3);
    wait_drained();
  endtask

  // out of range ids and the spare op code leave the mutex alone; task 15 then takes and frees it
  task automatic test_bad_requests();
    send_req(OP_LOCK, 8'd16);
    send_req(OP_UNLOCK, 8'hff);
    send_req(OP_TRY, 8'h80);
    send_req(OP_SPARE, 8'd0);
    send_req(OP_SPARE, 8'hff);
    send_req(OP_TRY, 8'd15);
    send_req(OP_UNLOCK, 8'd15);
    wait_drained();
  endtask

  // fifo hand-off, including a task queued twice
  task automatic test_queue_handoff();
    send_req(OP_LOCK, 8'd0);
    send_req(OP_LOCK, 8'd15);
    send_req(OP_LOCK, 8'd7);
    send_req(OP_LOCK, 8'd15);
    send_req(OP_UNLOCK, 8'd0);
    send_req(OP_UNLOCK, 8'd15);
    send_req(OP_UNLOCK, 8'd7);
    send_req(OP_UNLOCK, 8'd15);
    wait_drained();
  endtask

  // receiver holds off at the start, then the ring fills up to full and drains by hand-off
  task automatic test_stall_fill();
    hold_ask++;
    send_req(OP_LOCK, 8'd1);
    for (int i = 0; i < MAX_TASKS; i++) send_req(OP_LOCK, 8'(2 + $urandom_range(13)));
    send_req(OP_LOCK, 8'd0);
    send_req(OP_TRY, 8'd2);
    for (int i = 0; i <= MAX_TASKS; i++) begin
      if (i == 5) send_req(OP_UNLOCK, 8'(wrap_inc(mx_owner)));
      send_req(OP_UNLOCK, 8'(mx_owner));
    end
    wait_drained();
  endtask

  // random request biased by the shadow state, filling or draining the ring
  task automatic send_random_req(input bit filling);
    int dice;
    logic [1:0] op;
    logic [7:0] caller;
    dice = $urandom_range(99);
    op = OP_LOCK;
    caller = 8'($urandom_range(MAX_TASKS - 1));
    if (dice < 6) begin
      caller = 8'($urandom_range(255, MAX_TASKS));
      op = 2'($urandom_range(3));
    end else if (dice < 9) begin
      op = OP_SPARE;
    end else if (mx_held && dice < (filling ? 20 : 65)) begin
      op = OP_UNLOCK;
      caller = 8'(mx_owner);
    end else if (dice < 75) begin
      op = OP_LOCK;
    end else if (dice < 90) begin
      op = OP_TRY;
    end else begin
      op = OP_UNLOCK;
    end
    send_req(op, caller);
  endtask

  task automatic test_random(input int count);
    bit filling;
    filling = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (i % 48 == 0) filling = 1'($urandom_range(1));
      send_random_req(filling);
    end
    wait_drained();
  endtask

  initial begin
    mx_held = 1'b0;
    mx_owner = '0;
    wait_head = '0;
    wait_tail = '0;
    wait_cnt = '0;
    src_idle_pct = 8;
    sink_idle_pct = 59;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_grant();
    test_bad_requests();
    test_queue_handoff();
    test_stall_fill();
    test_random(360);

    src_idle_pct = 59;
    sink_idle_pct = 8;
    test_random(360);

    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random(360);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && rsp_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
